/* design/range_min_segment_tree_macros.svh */
// assertion macros used by the range minimum segment tree checker
`ifndef RANGE_MIN_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_SEGMENT_TREE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RMST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define RMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define RMST_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rmst_pkg.sv */
// shared types, codes and helpers for the range minimum segment tree
`timescale 1ns / 1ps

package rmst_pkg;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_QRY,
        ST_QOUT
    } state_t;

    function automatic logic signed [31:0] min_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return (a <= b) ? a : b;
    endfunction

endpackage

/* design/range_min_segment_tree.sv */
// range minimum segment tree over LEAVES signed 32-bit values, held in one memory
//
// input channel s_*: s_func selects a query (FUNC_QUERY) over positions
// s_position_low..s_range_high inclusive, or a point update (FUNC_UPDATE)
// writing s_new_value at s_position_low. updates give no result; updates at a
// position >= LEAVES are dropped. a query high bound >= LEAVES is cut to
// LEAVES - 1; an empty range answers 32'h7fffffff.
// result channel m_*: one m_range_minimum transfer per query.
// one item at a time. an update walks the tree one level per cycle (read
// sibling, write parent). a query walks both range bounds up one level per
// cycle through the two read ports, folding the nodes into its result register.
// after reset the block sweeps all 2 * LEAVES tree memory nodes to 32'h7fffffff,
// one node per cycle, with s_ready low.
// when the receiver stalls, a finished result waits in the output register;
// the next item is still taken, and a later query holds its minimum until the
// output register is free.
`timescale 1ns / 1ps

module range_min_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [9:0]         s_position_low,
    input  logic [9:0]         s_range_high,
    input  logic signed [31:0] s_new_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_range_minimum
);

    localparam int NODES = 2 * LEAVES;
    localparam int NW    = $clog2(NODES);
    localparam int RW    = NW + 1;

    logic signed [31:0] mem [NODES];

    state_t             state_reg, state_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [NW-1:0]      k_reg, k_next;
    logic signed [31:0] cur_reg, cur_next;
    logic [RW-1:0]      l_reg, l_next;
    logic [RW-1:0]      r_reg, r_next;
    logic               ta_reg, ta_next;
    logic               tb_reg, tb_next;
    logic signed [31:0] best_reg, best_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_data_reg, m_data_next;

    logic               mem_we;
    logic [NW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic [NW-1:0]      mem_ra_a;
    logic [NW-1:0]      mem_ra_b;
    logic signed [31:0] rda_reg;
    logic signed [31:0] rdb_reg;

    logic               accept;
    logic               pos_ok;
    logic [9:0]         hi_clamp;
    logic [NW-1:0]      leaf;
    logic [NW-1:0]      parent;
    logic [RW-1:0]      r_m1;
    logic signed [31:0] fold_a;
    logic signed [31:0] fold_b;
    logic signed [31:0] upd_min;

    assign s_ready         = (state_reg == ST_IDLE);
    assign accept          = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_range_minimum = m_data_reg;

    assign pos_ok   = 32'(s_position_low) < 32'(LEAVES);
    assign hi_clamp = (32'(s_range_high) >= 32'(LEAVES)) ? 10'(LEAVES - 1) : s_range_high;
    assign leaf     = NW'(s_position_low) + NW'(LEAVES);
    assign parent   = k_reg >> 1;
    assign r_m1     = r_reg - 1'b1;
    assign upd_min  = min_s(cur_reg, rda_reg);

    // fold the node values read in the previous cycle into the running minimum
    assign fold_a = ta_reg ? min_s(best_reg, rda_reg) : best_reg;
    assign fold_b = tb_reg ? min_s(fold_a, rdb_reg) : fold_a;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        ta_next      = 1'b0;
        tb_next      = 1'b0;
        best_next    = best_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wa       = clr_reg;
        mem_wd       = INT_MAX;
        mem_ra_a     = l_reg[NW-1:0];
        mem_ra_b     = r_m1[NW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_UPDATE) begin
                        if (pos_ok) begin
                            mem_we     = 1'b1;
                            mem_wa     = leaf;
                            mem_wd     = s_new_value;
                            mem_ra_a   = leaf ^ NW'(1);
                            k_next     = leaf;
                            cur_next   = s_new_value;
                            state_next = ST_UPD;
                        end
                    end else begin
                        best_next  = INT_MAX;
                        state_next = ST_QRY;
                        if (32'(s_position_low) > 32'(hi_clamp)) begin
                            l_next = '0;
                            r_next = '0;
                        end else begin
                            l_next = RW'(s_position_low) + RW'(LEAVES);
                            r_next = RW'(hi_clamp) + RW'(LEAVES) + RW'(1);
                        end
                    end
                end
            end
            ST_UPD: begin
                // sibling arrived; write parent and fetch the parent's sibling
                mem_we   = 1'b1;
                mem_wa   = parent;
                mem_wd   = upd_min;
                mem_ra_a = parent ^ NW'(1);
                cur_next = upd_min;
                k_next   = parent;
                if (parent == NW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY: begin
                best_next = fold_b;
                if (l_reg < r_reg) begin
                    ta_next = l_reg[0];
                    tb_next = r_reg[0];
                    l_next  = (l_reg + RW'(l_reg[0])) >> 1;
                    r_next  = (r_reg - RW'(r_reg[0])) >> 1;
                end else begin
                    state_next = ST_QOUT;
                end
            end
            ST_QOUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = best_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            ta_reg      <= 1'b0;
            tb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ta_reg      <= ta_next;
            tb_reg      <= tb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        best_reg   <= best_next;
        m_data_reg <= m_data_next;
    end

    // tree memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rda_reg <= mem[mem_ra_a];
        rdb_reg <= mem[mem_ra_b];
    end

endmodule

/* design/rmst_checker.sv */
// port-level checks for the range minimum segment tree, bound to the top level
`timescale 1ns / 1ps
`include "range_min_segment_tree_macros.svh"

module rmst_checker
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_func,
    input logic [9:0]         s_position_low,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_range_minimum
);

    logic m_stall;
    logic qry_xfer;
    logic upd_xfer;

    assign m_stall  = m_valid && !m_ready;
    assign qry_xfer = s_valid && s_ready && s_func == FUNC_QUERY;
    assign upd_xfer = s_valid && s_ready && s_func == FUNC_UPDATE
                      && 32'(s_position_low) < 32'(LEAVES);

    // a stalled result transfer keeps its data
    `RMST_ASSERT_NEXT(a_m_hold, m_stall, m_valid && $stable(m_range_minimum), "result not held")

    // reset starts the clearing sweep with both channels quiet
    `RMST_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !s_ready && !m_valid, "busy after reset")

    // an accepted query always keeps the input channel busy while the query runs
    `RMST_ASSERT_NEXT(a_query_busy, qry_xfer, !s_ready, "input ready right after a query")

    // a presented result never carries unknown bits
    `RMST_ASSERT_NOW(a_m_known, m_valid, !$isunknown(m_range_minimum), "unknown result data")

    // an in-range update walks the tree before the next item
    `RMST_ASSERT_NEXT(a_update_busy, upd_xfer, !s_ready, "input ready right after an update")

endmodule

bind range_min_segment_tree rmst_checker #(.LEAVES(LEAVES)) u_rmst_checker (.*);
